/* sv/gcev_pkg.sv */
// ----------------------------------------------------------------------------
// gcev_pkg
// Shared types and constants for the gamepad change event generator.
// ----------------------------------------------------------------------------
package gcev_pkg;

  localparam int unsigned PADS      = 4;
  localparam int unsigned PAD_W     = 2;
  localparam int unsigned NUM_BTN   = 14;
  localparam int unsigned NUM_AXES  = 4;
  localparam int unsigned DZ_W      = 15;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DZ_W-1:0] DZ_LEFT_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0] DZ_RIGHT_RESET = 15'd8689;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 1'b1;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_AXIS    = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic             present;
    logic [31:0]      packet_number;
    logic [15:0]      button_bits;
    logic [15:0]      left_x;
    logic [15:0]      left_y;
    logic [15:0]      right_x;
    logic [15:0]      right_y;
  } in_word_t;

  typedef struct packed {
    logic [PAD_W-1:0] source_pad;
    logic [1:0]       event_kind;
    logic [3:0]       code;
    logic [15:0]      axis_value;
    logic             last;
  } out_word_t;

  // axis lane control
  typedef struct packed {
    logic start;
    logic busy;
  } lane_ctl_t;

  // button bit position for a button code
  function automatic logic [3:0] btn_bit(input logic [3:0] c);
    btn_bit = (c < 4'd10) ? c : 4'(c + 4'd2);
  endfunction

endpackage

/* sv/gcev_if.sv */
// ----------------------------------------------------------------------------
// gcev_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface gcev_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/gcev_axis_lane.sv */
// ----------------------------------------------------------------------------
// gcev_axis_lane
// One axis: deadzone, then restoring divide of w*32768 by (32768-dz).
// ----------------------------------------------------------------------------
module gcev_axis_lane
  import gcev_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [15:0]     raw_i,
  input  logic [DZ_W-1:0] dz_i,
  output logic            busy_o,
  output logic [15:0]     value_o
);

  logic signed [16:0] v, d;
  logic        dead, neg;
  logic [15:0] mag;
  logic [31:0] rem_q, rem_d;    // shifting dividend/quotient
  logic [16:0] part_q, part_d;  // partial remainder
  logic [16:0] den_q;
  logic        neg_q, neg_d, dead_q, dead_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [17:0] trial;

  assign v    = 17'(signed'(raw_i));
  assign d    = signed'({2'b00, dz_i});
  assign neg  = v < 0;
  assign dead = neg ? (v >= -d) : (v < d);
  assign mag  = neg ? 16'(-(v + d)) : 16'(v - d);
  assign trial = {part_q, rem_q[31]} - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    part_d = part_q;
    neg_d  = neg_q;
    dead_d = dead_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rem_d  = {1'b0, mag, 15'd0};
      part_d = '0;
      neg_d  = neg;
      dead_d = dead;
      cnt_d  = 5'd31;
    end else if (cnt_q != 5'd0) begin
      if (!trial[17]) begin
        part_d = trial[16:0];
        rem_d  = {rem_q[30:0], 1'b1};
      end else begin
        part_d = {part_q[15:0], rem_q[31]};
        rem_d  = {rem_q[30:0], 1'b0};
      end
      cnt_d = 5'(cnt_q - 5'd1);
    end
  end

  // 32 quotient bits; count runs 31 steps plus the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    part_q <= part_d;
    neg_q  <= neg_d;
    dead_q <= dead_d;
    if (start_i) den_q <= 17'(17'd32768 - {2'b00, dz_i});
  end

  // final step combined into output
  assign busy_o  = cnt_q != 5'd0;
  logic [15:0] qf;
  assign qf      = 16'({rem_q[30:0], !trial[17]});
  assign value_o = dead_q ? 16'd0 : (neg_q ? 16'(-qf) : qf);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o) else $error("lane did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !start_i |=> cnt_q == 5'($past(cnt_q) - 5'd1))
    else $error("lane count skipped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !start_i |=> !busy_o) else $error("lane woke alone");

endmodule

/* sv/gcev_merge.sv */
// ----------------------------------------------------------------------------
// gcev_merge
// Picks the next event from button and axis change masks, lowest first.
// ----------------------------------------------------------------------------
module gcev_merge
  import gcev_pkg::*;
(
  input  logic [NUM_BTN-1:0]  btn_pend_i,
  input  logic [NUM_BTN-1:0]  btn_now_i,
  input  logic [NUM_AXES-1:0] ax_pend_i,
  input  logic [15:0]         ax_val_i [NUM_AXES],
  output logic                any_o,
  output logic                is_last_o,
  output logic [1:0]          kind_o,
  output logic [3:0]          code_o,
  output logic [15:0]         value_o
);

  logic [NUM_BTN+NUM_AXES-1:0] all, rest;
  logic [4:0] sel;

  assign all = {ax_pend_i, btn_pend_i};

  always_comb begin
    sel = '0;
    for (int i = NUM_BTN + NUM_AXES - 1; i >= 0; i--) begin
      if (all[i]) sel = 5'(i);
    end
  end

  always_comb begin
    rest = all;
    rest[sel] = 1'b0;
  end

  assign any_o     = |all;
  assign is_last_o = rest == '0;

  always_comb begin
    if (sel < 5'(NUM_BTN)) begin
      code_o  = sel[3:0];
      kind_o  = btn_now_i[sel[3:0]] ? EV_PRESS : EV_RELEASE;
      value_o = '0;
    end else begin
      code_o  = 4'(sel - 5'(NUM_BTN));
      kind_o  = EV_AXIS;
      value_o = ax_val_i[2'(sel - 5'(NUM_BTN))];
    end
  end

endmodule

/* sv/gamepad_change_event_generator_top.sv */
// ----------------------------------------------------------------------------
// gamepad_change_event_generator_top
// Per-slot change detector: button edges and deadzoned Q1.15 axis events.
// ----------------------------------------------------------------------------
// Flow: a report with changes starts the axis lanes, waits in ST_DIV while
//   they divide, then raises valid on its first event in ST_EMIT.
// Throughput: one report at a time, accepted only in ST_IDLE; four axis lanes
//   run a 32-step restoring divide in parallel before the events go out.
// Reset: all slots unseen, history zero, deadzones at 7849 / 8689.
// Reports with no effect leave the block in ST_IDLE, ready for the next.
module gamepad_change_event_generator_top
  import gcev_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gcev_if.sink                 in_if,
  gcev_if.source               out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DZ_W-1:0]      cfg_data_i
);

  state_e state_q, state_d;

  logic [DZ_W-1:0] dz_left_q, dz_right_q;
  logic [15:0]     prev_btn_q [PADS];
  logic [15:0]     prev_ax_q  [PADS][NUM_AXES];
  logic [31:0]     prev_pkt_q [PADS];

  in_word_t in_w;
  logic [PAD_W-1:0] pad_q;
  logic [NUM_BTN-1:0]  btn_pend_q, btn_pend_d, btn_now_q;
  logic [NUM_AXES-1:0] ax_pend_q, ax_pend_d;
  logic accept, fire, do_emit, store;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_left_q  <= DZ_LEFT_RESET;
      dz_right_q <= DZ_RIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LEFT_DZ)  dz_left_q  <= cfg_data_i;
      if (cfg_idx_i == CFG_RIGHT_DZ) dz_right_q <= cfg_data_i;
    end
  end

  assign in_w = in_if.data;
  assign in_if.ready = state_q == ST_IDLE;
  assign accept = in_if.valid && in_if.ready;

  // change masks for the incoming report
  logic [31:0] old_pkt;
  logic [15:0] old_btn, cur_ax [NUM_AXES];
  assign old_pkt = prev_pkt_q[in_w.pad];
  assign old_btn = prev_btn_q[in_w.pad];
  assign cur_ax[0] = in_w.left_x;
  assign cur_ax[1] = in_w.left_y;
  assign cur_ax[2] = in_w.right_x;
  assign cur_ax[3] = in_w.right_y;

  always_comb begin
    for (int i = 0; i < NUM_BTN; i++) begin
      btn_pend_d[i] = in_w.button_bits[btn_bit(4'(i))] ^ old_btn[btn_bit(4'(i))];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      ax_pend_d[a] = prev_ax_q[in_w.pad][a] != cur_ax[a];
    end
  end

  // store when first seen or new packet; fire when events may result
  assign store = accept && in_w.present && (old_pkt == 32'd0 || old_pkt != in_w.packet_number);
  assign fire  = store && old_pkt != 32'd0 && ((|btn_pend_d) || (|ax_pend_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PADS; p++) begin
        prev_btn_q[p] <= '0;
        prev_pkt_q[p] <= '0;
        for (int a = 0; a < NUM_AXES; a++) prev_ax_q[p][a] <= '0;
      end
    end else if (store) begin
      prev_btn_q[in_w.pad] <= in_w.button_bits;
      prev_pkt_q[in_w.pad] <= in_w.packet_number;
      for (int a = 0; a < NUM_AXES; a++) prev_ax_q[in_w.pad][a] <= cur_ax[a];
    end
  end

  // axis lanes
  logic [NUM_AXES-1:0] lane_busy;
  logic [15:0]         lane_val [NUM_AXES];
  lane_ctl_t           lane_ctl;
  assign lane_ctl.start = fire;
  assign lane_ctl.busy  = |lane_busy;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    gcev_axis_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_ctl.start),
      .raw_i   (cur_ax[a]),
      .dz_i    ((a < 2) ? dz_left_q : dz_right_q),
      .busy_o  (lane_busy[a]),
      .value_o (lane_val[a])
    );
  end

  // merge
  logic m_any, m_last;
  logic [1:0] m_kind;
  logic [3:0] m_code;
  logic [15:0] m_val;
  gcev_merge u_merge (
    .btn_pend_i (btn_pend_q),
    .btn_now_i  (btn_now_q),
    .ax_pend_i  (ax_pend_q),
    .ax_val_i   (lane_val),
    .any_o      (m_any),
    .is_last_o  (m_last),
    .kind_o     (m_kind),
    .code_o     (m_code),
    .value_o    (m_val)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (fire) state_d = ST_DIV;
      ST_DIV:  if (!lane_ctl.busy) state_d = ST_EMIT;
      ST_EMIT: if (do_emit && m_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_if.valid = state_q == ST_EMIT;
    out_if.data  = '{source_pad: pad_q, event_kind: m_kind, code: m_code,
                     axis_value: m_val, last: m_last};
  end
  assign do_emit = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      btn_pend_q <= '0;
      ax_pend_q  <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        btn_pend_q <= btn_pend_d;
        ax_pend_q  <= ax_pend_d;
      end else if (do_emit) begin
        {ax_pend_q, btn_pend_q} <= {ax_pend_q, btn_pend_q} &
          ({ax_pend_q, btn_pend_q} - (NUM_BTN+NUM_AXES)'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pad_q <= in_w.pad;
      for (int i = 0; i < NUM_BTN; i++) btn_now_q[i] <= in_w.button_bits[btn_bit(4'(i))];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> m_any) else $error("emit with nothing pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !lane_ctl.busy) else $error("emit while dividing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_emit && m_last |=> state_q == ST_IDLE) else $error("no return after last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> state_q == ST_DIV) else $error("fire lost");

endmodule
